// ===== rtl/core/fpp_pkg.sv =====
`default_nettype none

package fpp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    // event codes on the result channel
    localparam logic [EVENT_W-1:0] EV_DATA   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_ACCEPT = 2'd1;
    localparam logic [EVENT_W-1:0] EV_REJECT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN       = 2'd2;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;
    localparam logic [BYTE_W-1:0] MAX_LEN_RST       = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] max_payload_len;
    } cfg_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  data_byte;
        logic [BYTE_W-1:0]  byte_index;
        logic [BYTE_W-1:0]  message_id;
        logic [BYTE_W-1:0]  sequence_no;
        logic [BYTE_W-1:0]  length_field;
        logic [COUNT_W-1:0] good_frames;
    } result_t;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } buf_status_t;

    // CRC-16/MODBUS, one byte, LSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = acc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fpp_parser.sv =====
`default_nettype none

module fpp_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire logic [7:0]      rx_byte,
    input  wire fpp_pkg::cfg_t   cfg,
    output logic                 res_valid,
    output fpp_pkg::result_t     res
);

    localparam logic [2:0] PH_HEAD0 = 3'd0;
    localparam logic [2:0] PH_HEAD1 = 3'd1;
    localparam logic [2:0] PH_ID    = 3'd2;
    localparam logic [2:0] PH_SEQ   = 3'd3;
    localparam logic [2:0] PH_LEN   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CRCLO = 3'd6;
    localparam logic [2:0] PH_CRCHI = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  len_reg, len_next;
    logic [31:0] count_reg, count_next;

    logic [15:0] crc_upd;
    logic [7:0]  pos_inc;

    assign crc_upd = fpp_pkg::crc_byte(crc_reg, rx_byte);
    assign pos_inc = pos_reg + 8'd1;

    always_comb begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        pos_next    = pos_reg;
        id_next     = id_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        res_valid   = 1'b0;
        res.event_res    = fpp_pkg::EV_DATA;
        res.data_byte    = 8'd0;
        res.byte_index   = 8'd0;
        res.message_id   = id_reg;
        res.sequence_no  = seq_reg;
        res.length_field = len_reg;
        res.good_frames  = count_reg;
        if (accept) begin
            case (phase_reg)
                PH_HEAD0: begin
                    if (rx_byte == cfg.header_first) begin
                        phase_next = PH_HEAD1;
                    end
                end
                PH_HEAD1: begin
                    // a wrong second byte is not retried as a first header byte
                    if (rx_byte == cfg.header_second) begin
                        phase_next = PH_ID;
                        crc_next   = fpp_pkg::CRC_INIT;
                        pos_next   = 8'd0;
                    end else begin
                        phase_next = PH_HEAD0;
                    end
                end
                PH_ID: begin
                    id_next    = rx_byte;
                    crc_next   = crc_upd;
                    phase_next = PH_SEQ;
                end
                PH_SEQ: begin
                    seq_next   = rx_byte;
                    crc_next   = crc_upd;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    len_next = rx_byte;
                    crc_next = crc_upd;
                    pos_next = 8'd0;
                    // drop oversize frames silently
                    if (rx_byte > cfg.max_payload_len) begin
                        phase_next = PH_HEAD0;
                    end else if (rx_byte == 8'd0) begin
                        phase_next = PH_CRCLO;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    crc_next       = crc_upd;
                    res_valid      = 1'b1;
                    res.data_byte  = rx_byte;
                    res.byte_index = pos_reg;
                    pos_next       = pos_inc;
                    if (pos_inc >= len_reg) begin
                        phase_next = PH_CRCLO;
                    end
                end
                PH_CRCLO: begin
                    crc_lo_next = rx_byte;
                    phase_next  = PH_CRCHI;
                end
                PH_CRCHI: begin
                    phase_next = PH_HEAD0;
                    res_valid  = 1'b1;
                    if ({rx_byte, crc_lo_reg} == crc_reg) begin
                        count_next      = count_reg + 32'd1;
                        res.event_res   = fpp_pkg::EV_ACCEPT;
                        res.good_frames = count_reg + 32'd1;
                    end else begin
                        res.event_res = fpp_pkg::EV_REJECT;
                    end
                end
                default: begin
                    phase_next = PH_HEAD0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEAD0;
            crc_reg    <= fpp_pkg::CRC_INIT;
            crc_lo_reg <= 8'd0;
            pos_reg    <= 8'd0;
            id_reg     <= 8'd0;
            seq_reg    <= 8'd0;
            len_reg    <= 8'd0;
            count_reg  <= 32'd0;
        end else begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
            pos_reg    <= pos_next;
            id_reg     <= id_next;
            seq_reg    <= seq_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fpp_out_buf.sv =====
`default_nettype none

module fpp_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire fpp_pkg::result_t  push_data,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output fpp_pkg::result_t       out_data,
    output fpp_pkg::buf_status_t   status
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    fpp_pkg::result_t out_reg, out_next;
    fpp_pkg::result_t skid_reg, skid_next;
    logic             pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign status.out_valid  = out_valid_reg;
    assign status.skid_valid = skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            // advance the skid entry once the output is taken
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/framed_packet_parser_crc16_unit.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_rx_byte
// m_        out        m_valid/m_ready    m_event_res .. m_good_frames
// cfg_      in         cfg_wr_en only     cfg_index, cfg_wdata
//
// One received byte is taken every cycle while s_ready is high; the byte-wide
// CRC update and the frame state step sit between the input and the output
// register. Each result is registered before it appears on m_.
// An output register plus one skid entry decouple the sides: s_ready drops
// only while both hold a request, i.e. after m_ has stalled for two results.
// aresetn is synchronous; reset returns the hunt and restores the headers and length limit.
`default_nettype none

module framed_packet_parser_crc16_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_event_res,
    output logic [7:0]       m_data_byte,
    output logic [7:0]       m_byte_index,
    output logic [7:0]       m_message_id,
    output logic [7:0]       m_sequence_no,
    output logic [7:0]       m_length_field,
    output logic [31:0]      m_good_frames,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    fpp_pkg::cfg_t        cfg_reg, cfg_next;
    fpp_pkg::result_t     res;
    fpp_pkg::result_t     out_data;
    fpp_pkg::buf_status_t buf_status;
    logic                 res_valid;
    logic                 accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                fpp_pkg::CFG_HEADER_FIRST:  cfg_next.header_first    = cfg_wdata;
                fpp_pkg::CFG_HEADER_SECOND: cfg_next.header_second   = cfg_wdata;
                fpp_pkg::CFG_MAX_LEN:       cfg_next.max_payload_len = cfg_wdata;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first    <= fpp_pkg::HEADER_FIRST_RST;
            cfg_reg.header_second   <= fpp_pkg::HEADER_SECOND_RST;
            cfg_reg.max_payload_len <= fpp_pkg::MAX_LEN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fpp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    fpp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data),
        .status    (buf_status)
    );

    assign m_event_res    = out_data.event_res;
    assign m_data_byte    = out_data.data_byte;
    assign m_byte_index   = out_data.byte_index;
    assign m_message_id   = out_data.message_id;
    assign m_sequence_no  = out_data.sequence_no;
    assign m_length_field = out_data.length_field;
    assign m_good_frames  = out_data.good_frames;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_status.skid_valid |-> buf_status.out_valid)
        else $error("skid entry held with empty output register");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (buf_status.skid_valid && !m_ready) |=> (buf_status.skid_valid && !s_ready))
        else $error("stalled buffer lost a request");

    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_res == fpp_pkg::EV_DATA || m_event_res == fpp_pkg::EV_ACCEPT
                     || m_event_res == fpp_pkg::EV_REJECT))
        else $error("undefined event code on output");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_status.skid_valid |-> !res_valid)
        else $error("result produced while buffer full");
`endif

endmodule

`default_nettype wire
